// File: sv/bcl_pkg.sv
// Shared types, constants and helpers for the button click and long-press detector.
`default_nettype none
package bcl_pkg;

  localparam int unsigned TIMER_WIDTH   = 16;
  localparam int unsigned STAMP_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH   = 8;
  localparam int unsigned CFG_WIDTH     = 16;
  localparam int unsigned CFG_IDX_WIDTH = 3;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLICK_MAX   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_PRESS  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_REPEAT = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLICK_GAP   = 3'd4;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST    = 16'd100;
  localparam logic [CFG_WIDTH-1:0] CLICK_MAX_RST   = 16'd750;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST  = 16'd750;
  localparam logic [CFG_WIDTH-1:0] LONG_REPEAT_RST = 16'd250;
  localparam logic [CFG_WIDTH-1:0] CLICK_GAP_RST   = 16'd100;

  typedef enum logic [3:0] {
    PH_RELEASED   = 4'b0001,
    PH_PRESS_DB   = 4'b0010,
    PH_PRESSED    = 4'b0100,
    PH_RELEASE_DB = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2,
    EV_CLICK    = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce;
    logic [CFG_WIDTH-1:0] click_max;
    logic [CFG_WIDTH-1:0] long_first;
    logic [CFG_WIDTH-1:0] long_repeat;
    logic [CFG_WIDTH-1:0] click_gap;
  } cfg_t;

  typedef struct packed {
    event_kind_e            kind;
    logic [COUNT_WIDTH-1:0] clicks;
    logic [COUNT_WIDTH-1:0] repeats;
    logic [STAMP_WIDTH-1:0] stamp;
  } evt_t;

  function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
  endfunction

endpackage
`default_nettype wire

// File: sv/bcl_in_if.sv
// Input channel carrying one sampled button level per transaction.
`default_nettype none
interface bcl_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface
`default_nettype wire

// File: sv/bcl_out_if.sv
// Output channel carrying one button event per transaction.
`default_nettype none
interface bcl_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     event_kind;
  logic [bcl_pkg::COUNT_WIDTH-1:0] clicks;
  logic [bcl_pkg::COUNT_WIDTH-1:0] repeats;
  logic [bcl_pkg::STAMP_WIDTH-1:0] stamp;

  modport source (output valid, output event_kind, output clicks, output repeats,
                  output stamp, input ready);
  modport sink (input valid, input event_kind, input clicks, input repeats,
                input stamp, output ready);
endinterface
`default_nettype wire

// File: sv/bcl_fsm.sv
// Button phase machine, countdown timer, stamps and counters with event generation.
`default_nettype none
module bcl_fsm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          level_i,
  input  wire bcl_pkg::cfg_t cfg_i,
  output logic               ev_valid_o,
  output bcl_pkg::evt_t      ev_o
);

  bcl_pkg::phase_e                     phase_q, phase_d;
  logic [bcl_pkg::TIMER_WIDTH-1:0]     timer_q, timer_d;
  logic                                armed_q, armed_d;
  logic [bcl_pkg::STAMP_WIDTH-1:0]     tick_q, tick_d;
  logic [bcl_pkg::STAMP_WIDTH-1:0]     press_q, press_d;
  logic [bcl_pkg::STAMP_WIDTH-1:0]     release_q, release_d;
  logic [bcl_pkg::COUNT_WIDTH-1:0]     click_q, click_d;
  logic [bcl_pkg::COUNT_WIDTH-1:0]     repeat_q, repeat_d;

  logic                                edge_press, edge_release, expire;
  logic                                do_press, do_release;
  logic [bcl_pkg::STAMP_WIDTH-1:0]     hold_span;

  assign edge_press   = (phase_q == bcl_pkg::PH_RELEASED) && !level_i;
  assign edge_release = (phase_q == bcl_pkg::PH_PRESSED) && level_i;
  assign expire       = !edge_press && !edge_release && armed_q &&
                        (timer_q <= bcl_pkg::TIMER_WIDTH'(1));
  assign do_press     = edge_press ||
                        (expire && (phase_q == bcl_pkg::PH_RELEASE_DB) && !level_i);
  assign do_release   = edge_release ||
                        (expire && (phase_q == bcl_pkg::PH_PRESS_DB) && level_i);
  assign hold_span    = release_q - press_q;

  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_q;
    armed_d    = armed_q;
    tick_d     = tick_q;
    press_d    = press_q;
    release_d  = release_q;
    click_d    = click_q;
    repeat_d   = repeat_q;
    ev_valid_o = 1'b0;
    ev_o       = '{kind: bcl_pkg::EV_PRESSED, clicks: click_q, repeats: repeat_q,
                   stamp: tick_q};
    if (step_i) begin
      tick_d = tick_q + bcl_pkg::STAMP_WIDTH'(1);
      if (edge_press || edge_release || expire) begin
        armed_d = 1'b0;
        timer_d = '0;
      end else if (armed_q) begin
        timer_d = timer_q - bcl_pkg::TIMER_WIDTH'(1);
      end
      if (do_press) begin
        phase_d    = bcl_pkg::PH_PRESS_DB;
        press_d    = tick_q;
        click_d    = bcl_pkg::count_inc(click_q);
        repeat_d   = '0;
        ev_valid_o = 1'b1;
        ev_o.kind  = bcl_pkg::EV_PRESSED;
        ev_o.clicks  = click_d;
        ev_o.repeats = '0;
        timer_d    = cfg_i.debounce;
        armed_d    = 1'b1;
      end else if (do_release) begin
        phase_d    = bcl_pkg::PH_RELEASE_DB;
        release_d  = tick_q;
        repeat_d   = '0;
        ev_valid_o = 1'b1;
        ev_o.kind  = bcl_pkg::EV_RELEASED;
        ev_o.repeats = '0;
        timer_d    = cfg_i.debounce;
        armed_d    = 1'b1;
      end else if (expire) begin
        case (phase_q)
          bcl_pkg::PH_RELEASE_DB: begin
            phase_d = bcl_pkg::PH_RELEASED;
            if (hold_span <= bcl_pkg::STAMP_WIDTH'(cfg_i.click_max)) begin
              timer_d = cfg_i.click_gap;
              armed_d = 1'b1;
            end else begin
              click_d = '0;
            end
          end
          bcl_pkg::PH_PRESS_DB: begin
            phase_d = bcl_pkg::PH_PRESSED;
            timer_d = cfg_i.long_first;
            armed_d = 1'b1;
          end
          bcl_pkg::PH_RELEASED: begin
            if (repeat_q == '0) begin
              ev_valid_o = 1'b1;
              ev_o.kind  = bcl_pkg::EV_CLICK;
            end
            click_d = '0;
          end
          bcl_pkg::PH_PRESSED: begin
            repeat_d     = bcl_pkg::count_inc(repeat_q);
            ev_valid_o   = 1'b1;
            ev_o.kind    = bcl_pkg::EV_LONG;
            ev_o.repeats = repeat_d;
            timer_d      = cfg_i.long_repeat;
            armed_d      = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bcl_pkg::PH_RELEASED;
      timer_q   <= '0;
      armed_q   <= 1'b0;
      tick_q    <= '0;
      press_q   <= '0;
      release_q <= '0;
      click_q   <= '0;
      repeat_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      timer_q   <= timer_d;
      armed_q   <= armed_d;
      tick_q    <= tick_d;
      press_q   <= press_d;
      release_q <= release_d;
      click_q   <= click_d;
      repeat_q  <= repeat_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/button_click_longpress_detector.sv
// Top level of the debounced button detector with multi-click and long-press events.
// Flow: an accepted level is registered in the input register and then updates the
// state once the output register can take a result; an event it causes is loaded
// into the output register in that same update and is offered on the output from
// there. Throughput: one level per cycle, limited only by the single output register.
// Reset: asynchronous active low; released phase, timer stopped, counters and stamps
// cleared, configuration registers back to their default tick counts.
`default_nettype none
module button_click_longpress_detector (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bcl_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  wire logic [bcl_pkg::CFG_WIDTH-1:0]     cfg_data_i,
  bcl_in_if.sink                                 in_i,
  bcl_out_if.source                              out_o
);

  bcl_pkg::cfg_t  cfg_q;
  logic           s1_valid_q;
  logic           s1_level_q;
  logic           out_valid_q;
  bcl_pkg::evt_t  out_q;
  logic           advance;
  logic           ev_valid;
  bcl_pkg::evt_t  ev;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce    <= bcl_pkg::DEBOUNCE_RST;
      cfg_q.click_max   <= bcl_pkg::CLICK_MAX_RST;
      cfg_q.long_first  <= bcl_pkg::LONG_PRESS_RST;
      cfg_q.long_repeat <= bcl_pkg::LONG_REPEAT_RST;
      cfg_q.click_gap   <= bcl_pkg::CLICK_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcl_pkg::CFG_DEBOUNCE:    cfg_q.debounce    <= cfg_data_i;
        bcl_pkg::CFG_CLICK_MAX:   cfg_q.click_max   <= cfg_data_i;
        bcl_pkg::CFG_LONG_PRESS:  cfg_q.long_first  <= cfg_data_i;
        bcl_pkg::CFG_LONG_REPEAT: cfg_q.long_repeat <= cfg_data_i;
        bcl_pkg::CFG_CLICK_GAP:   cfg_q.click_gap   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_level_q <= in_i.pin_level;
    end
  end

  bcl_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .level_i    (s1_level_q),
    .cfg_i      (cfg_q),
    .ev_valid_o (ev_valid),
    .ev_o       (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ev_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && ev_valid) begin
      out_q <= ev;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_kind = out_q.kind;
  assign out_o.clicks     = out_q.clicks;
  assign out_o.repeats    = out_q.repeats;
  assign out_o.stamp      = out_q.stamp;

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("Accepted transaction did not reach the input register.");

  a_event_needs_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("Output became valid without a state update.");

  a_press_counts_click : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == bcl_pkg::EV_PRESSED)) |-> (out_q.clicks != '0))
    else $error("Pressed event with a zero click count.");

  a_edge_clears_repeats : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_q.kind == bcl_pkg::EV_PRESSED) ||
                     (out_q.kind == bcl_pkg::EV_RELEASED))) |-> (out_q.repeats == '0))
    else $error("Press or release event with a nonzero repeat count.");

  a_long_counts_repeat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == bcl_pkg::EV_LONG)) |-> (out_q.repeats != '0))
    else $error("Long press event with a zero repeat count.");

endmodule
`default_nettype wire
